[rtl/length_prefixed_nal_to_start_code_assert.svh]
// Assertion macros shared by the converter's modules.
`ifndef LENGTH_PREFIXED_NAL_TO_START_CODE_ASSERT_SVH
`define LENGTH_PREFIXED_NAL_TO_START_CODE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LPN2SC_ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("lpn2sc: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define LPN2SC_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("lpn2sc: next-cycle check failed");

`endif

[rtl/lpn2sc_pkg.sv]
// Types and constants shared by the length-prefixed to start-code converter.
package lpn2sc_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 32;
    localparam int SEEN_W      = 2;
    localparam int SIZE_W      = 3;
    localparam int BEAT_W      = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd4;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Index of the closing 01 byte within each start-code form
    localparam logic [BEAT_W-1:0] BEAT_END_LONG  = 2'd3;
    localparam logic [BEAT_W-1:0] BEAT_END_SHORT = 2'd2;

    localparam logic [BYTE_W-1:0] START_CODE_ONE = 8'h01;

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DROP    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CMD_DATA        = 2'd0,
        CMD_START_LONG  = 2'd1,
        CMD_START_SHORT = 2'd2,
        CMD_ERROR       = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BYTE_W-1:0]  data;
        logic               last;
    } cmd_t;

endpackage

[rtl/lpn2sc_front.sv]
// Front end: parse length prefixes and turn each input byte into at most one command.
`include "length_prefixed_nal_to_start_code_assert.svh"

module lpn2sc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lpn2sc_pkg::SIZE_W-1:0]   cfg_size,
    input  logic                            in_accept,
    input  logic [lpn2sc_pkg::BYTE_W-1:0]   in_byte,
    input  logic                            in_last,
    output logic                            push,
    output lpn2sc_pkg::cmd_t                push_cmd
);
    import lpn2sc_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    phase_t            phase_reg, phase_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [LEN_W-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic              first_reg, first_next;

    logic [SIZE_W-1:0] size_eff;
    logic [LEN_W-1:0]  acc_shift;
    logic [SEEN_W-1:0] seen_inc;
    logic              prefix_done;
    logic              len_negative;
    logic              rem_is_one;

    // Clamp prefix size into 1..4
    always_comb
    begin
        if (size_reg < SIZE_MIN)
            size_eff = SIZE_MIN;
        else if (size_reg > SIZE_MAX)
            size_eff = SIZE_MAX;
        else
            size_eff = size_reg;
    end

    assign acc_shift    = {acc_reg[LEN_W-BYTE_W-1:0], in_byte};
    assign seen_inc     = seen_reg + 1'b1;
    assign prefix_done  = (seen_inc == '0) || ({1'b0, seen_inc} >= size_eff);
    assign len_negative = (size_eff == SIZE_MAX) && acc_shift[LEN_W-1];
    assign rem_is_one   = (rem_reg == LEN_W'(1));

    // Command outputs
    always_comb
    begin
        push          = 1'b0;
        push_cmd.kind = CMD_DATA;
        push_cmd.data = in_byte;
        push_cmd.last = in_last;
        if (in_accept)
        begin
            case (phase_reg)
                PH_PAYLOAD:
                begin
                    push = 1'b1;
                    if (in_last && !rem_is_one)
                        push_cmd.kind = CMD_ERROR;
                end
                PH_PREFIX:
                begin
                    if (!prefix_done || len_negative || (acc_shift != '0))
                    begin
                        if (in_last)
                        begin
                            push          = 1'b1;
                            push_cmd.kind = CMD_ERROR;
                        end
                    end
                    if (prefix_done && !len_negative && !(in_last && acc_shift != '0))
                    begin
                        push          = 1'b1;
                        push_cmd.kind = first_reg ? CMD_START_LONG : CMD_START_SHORT;
                    end
                end
                default:
                begin
                    if (in_last)
                    begin
                        push          = 1'b1;
                        push_cmd.kind = CMD_ERROR;
                    end
                end
            endcase
            if (push_cmd.kind == CMD_ERROR)
            begin
                push_cmd.data = '0;
                push_cmd.last = 1'b1;
            end
        end
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        seen_next  = seen_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        first_next = first_reg;
        if (in_accept)
        begin
            case (phase_reg)
                PH_PAYLOAD:
                begin
                    rem_next = rem_reg - 1'b1;
                    if (rem_is_one)
                        phase_next = PH_PREFIX;
                end
                PH_PREFIX:
                begin
                    if (!prefix_done)
                    begin
                        acc_next  = acc_shift;
                        seen_next = seen_inc;
                    end
                    else if (len_negative)
                    begin
                        seen_next  = '0;
                        acc_next   = '0;
                        phase_next = PH_DROP;
                    end
                    else
                    begin
                        seen_next  = '0;
                        acc_next   = '0;
                        first_next = 1'b0;
                        rem_next   = acc_shift;
                        phase_next = (acc_shift != '0) ? PH_PAYLOAD : PH_PREFIX;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            // Every packet end returns the parser to its idle state
            if (in_last)
            begin
                phase_next = PH_PREFIX;
                seen_next  = '0;
                acc_next   = '0;
                rem_next   = '0;
                first_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_RESET;
            phase_reg <= PH_PREFIX;
            seen_reg  <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
                size_reg <= cfg_size;
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            first_reg <= first_next;
        end
    end

    `LPN2SC_ASSERT_IMPLIES(a_payload_nonzero, clk, rst_n, phase_reg == PH_PAYLOAD, rem_reg != '0)
    `LPN2SC_ASSERT_IMPLIES(a_drop_clean, clk, rst_n, phase_reg == PH_DROP, (acc_reg == '0) && (seen_reg == '0))

endmodule

[rtl/lpn2sc_queue.sv]
// Short command queue between the front and back ends.
`include "length_prefixed_nal_to_start_code_assert.svh"

module lpn2sc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lpn2sc_pkg::cmd_t  push_cmd,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output lpn2sc_pkg::cmd_t  head_cmd
);
    import lpn2sc_pkg::*;

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `LPN2SC_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
    `LPN2SC_ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, pop, count_reg != '0)

endmodule

[rtl/lpn2sc_back.sv]
// Back end: expand queued commands into output beats behind an output register.
`include "length_prefixed_nal_to_start_code_assert.svh"

module lpn2sc_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  lpn2sc_pkg::cmd_t                head_cmd,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lpn2sc_pkg::BYTE_W-1:0]   out_byte,
    output logic                            out_last,
    output logic                            out_error
);
    import lpn2sc_pkg::*;

    logic [BEAT_W-1:0] beat_idx_reg, beat_idx_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              error_reg;

    logic [BYTE_W-1:0] beat_byte;
    logic              beat_last;
    logic              beat_error;
    logic              beat_final;
    logic              load;

    // Shape of the beat at the current position of the head command
    always_comb
    begin
        beat_byte  = '0;
        beat_last  = 1'b0;
        beat_error = 1'b0;
        beat_final = 1'b1;
        case (head_cmd.kind)
            CMD_DATA:
            begin
                beat_byte = head_cmd.data;
                beat_last = head_cmd.last;
            end
            CMD_START_LONG:
            begin
                beat_final = (beat_idx_reg == BEAT_END_LONG);
                beat_byte  = beat_final ? START_CODE_ONE : '0;
                beat_last  = beat_final && head_cmd.last;
            end
            CMD_START_SHORT:
            begin
                beat_final = (beat_idx_reg == BEAT_END_SHORT);
                beat_byte  = beat_final ? START_CODE_ONE : '0;
                beat_last  = beat_final && head_cmd.last;
            end
            default:
            begin
                beat_last  = 1'b1;
                beat_error = 1'b1;
            end
        endcase
    end

    assign load = head_valid && (!valid_reg || !out_stall);
    assign pop  = load && beat_final;

    always_comb
    begin
        beat_idx_next = beat_idx_reg;
        if (load)
            beat_idx_next = beat_final ? '0 : beat_idx_reg + 1'b1;
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= beat_byte;
            last_reg  <= beat_last;
            error_reg <= beat_error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_idx_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            beat_idx_reg <= beat_idx_next;
            valid_reg    <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_error = error_reg;

    `LPN2SC_ASSERT_IMPLIES(a_error_shape, clk, rst_n, valid_reg && error_reg, last_reg && (byte_reg == '0))
    `LPN2SC_ASSERT_NEXT(a_code_advance, clk, rst_n, load && !beat_final, beat_idx_reg != '0)

endmodule

[rtl/length_prefixed_nal_to_start_code.sv]
// Top level of the length-prefixed NAL unit to start-code stream converter.
//
//   channel   direction  handshake                      payload
//   in        sink       in_valid / in_stall            in_byte, in_last
//   out       source     out_valid / out_stall          out_byte, out_last, out_error
//   config    sink       length_field_bytes_we          length_field_bytes
//
// One input beat is taken per cycle while the four-entry command queue has room.
// The output register gives one beat per cycle while out_stall is low; a start
// code is three or four beats, so prefix bytes that yield start codes fill the
// queue and then stall the input. With the queue empty and the output free, an
// accepted byte is written to the queue and then loaded into the output register.
// Reset (rst_n low, asynchronous) empties the queue and output register, sets the
// prefix size to four bytes and arms the long start code for the next unit.
//
// The front end parses prefixes and turns each byte into at most one command
// (copy a byte, emit a long or short start code, or flag an error). The back end
// drains the queue and expands start codes into beats. A malformed packet cannot
// take back beats already sent: drop the rest of it and close it with a single
// error beat (byte 0, last and error set).
module length_prefixed_nal_to_start_code (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            length_field_bytes_we,
    input  logic [lpn2sc_pkg::SIZE_W-1:0]   length_field_bytes,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [lpn2sc_pkg::BYTE_W-1:0]   in_byte,
    input  logic                            in_last,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lpn2sc_pkg::BYTE_W-1:0]   out_byte,
    output logic                            out_last,
    output logic                            out_error
);
    import lpn2sc_pkg::*;

    logic in_accept;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic queue_full;
    logic head_valid;
    cmd_t head_cmd;

    // Hold the input off only while the queue is full
    assign in_stall  = queue_full;
    assign in_accept = in_valid && !queue_full;

    lpn2sc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (length_field_bytes_we),
        .cfg_size  (length_field_bytes),
        .in_accept (in_accept),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    lpn2sc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    lpn2sc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .out_error  (out_error)
    );

endmodule
